>>> rtl/core/tgfa_pkg.sv
package tgfa_pkg;

   localparam int KEY_W   = 64;
   localparam int BYTE_W  = 8;
   localparam int FANOUT  = 256;
   localparam int LVL_W   = 3;
   localparam int VAL_W   = 13;
   localparam int CNT_W   = 13;
   localparam int EPOCH_W = 8;
   localparam int GRP_W   = 12;
   localparam int STAT_W  = 2;
   localparam int KB_W    = 4;
   localparam int TB_W    = 16;
   localparam int MB_W    = 32;
   localparam int NODE_SHIFT = 11;
   localparam int GC_W    = CNT_W + TB_W;
   localparam int NEED_W  = MB_W + 1;
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;
   localparam int IDX_W   = 2;

   localparam int DEF_MAX_KEY_BYTES = 8;
   localparam int DEF_MAX_NODES     = 256;
   localparam int DEF_MAX_GROUPS    = 4096;

   localparam logic [KB_W-1:0] KEY_BYTES_RST   = 4'd8;
   localparam logic [TB_W-1:0] TUPLE_BYTES_RST = 16'd8;
   localparam logic [MB_W-1:0] MEM_BYTES_RST   = 32'd1048576;

   localparam logic [IDX_W-1:0] REG_KEY_BYTES   = 2'd0;
   localparam logic [IDX_W-1:0] REG_TUPLE_BYTES = 2'd1;
   localparam logic [IDX_W-1:0] REG_MEM_BYTES   = 2'd2;

   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_ADDED = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_CHECK,
      ST_ALLOC
   } state_type;

   typedef struct packed {
      logic [KB_W-1:0] key_bytes;
      logic [TB_W-1:0] tuple_bytes;
      logic [MB_W-1:0] mem_bytes;
      logic            flush;
   } cfg_type;

   function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] key,
                                                  input logic [LVL_W-1:0] lvl);
      return key[{lvl, 3'b000} +: BYTE_W];
   endfunction

endpackage

>>> rtl/core/tgfa_ram.sv
module tgfa_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/tgfa_csr.sv
module tgfa_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tgfa_pkg::PADDR_W-1:0]  paddr,
   input  logic [tgfa_pkg::PDATA_W-1:0]  pwdata,
   output logic [tgfa_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready,
   output tgfa_pkg::cfg_type             cfg
);
   import tgfa_pkg::*;

   logic [KB_W-1:0]  key_bytes_ff, key_bytes_in;
   logic [TB_W-1:0]  tuple_bytes_ff, tuple_bytes_in;
   logic [MB_W-1:0]  mem_bytes_ff, mem_bytes_in;
   logic             wr;
   logic [IDX_W-1:0] idx;

   assign wr     = psel & penable & pwrite;
   assign idx    = paddr[IDX_W+1:2];
   assign pready = 1'b1;

   always_comb begin
      key_bytes_in   = key_bytes_ff;
      tuple_bytes_in = tuple_bytes_ff;
      mem_bytes_in   = mem_bytes_ff;
      if (wr) begin
         case (idx)
            REG_KEY_BYTES:   key_bytes_in   = pwdata[KB_W-1:0];
            REG_TUPLE_BYTES: tuple_bytes_in = pwdata[TB_W-1:0];
            REG_MEM_BYTES:   mem_bytes_in   = pwdata[MB_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff   <= KEY_BYTES_RST;
         tuple_bytes_ff <= TUPLE_BYTES_RST;
         mem_bytes_ff   <= MEM_BYTES_RST;
      end else begin
         key_bytes_ff   <= key_bytes_in;
         tuple_bytes_ff <= tuple_bytes_in;
         mem_bytes_ff   <= mem_bytes_in;
      end
   end

   always_comb begin
      case (idx)
         REG_KEY_BYTES:   prdata = PDATA_W'(key_bytes_ff);
         REG_TUPLE_BYTES: prdata = PDATA_W'(tuple_bytes_ff);
         REG_MEM_BYTES:   prdata = PDATA_W'(mem_bytes_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.key_bytes   = key_bytes_ff;
   assign cfg.tuple_bytes = tuple_bytes_ff;
   assign cfg.mem_bytes   = mem_bytes_ff;
   assign cfg.flush       = wr && (idx == REG_KEY_BYTES);

endmodule

>>> rtl/core/tgfa_walk.sv
module tgfa_walk #(
   parameter int MAX_KEY_BYTES = tgfa_pkg::DEF_MAX_KEY_BYTES,
   parameter int MAX_NODES     = tgfa_pkg::DEF_MAX_NODES,
   parameter int MAX_GROUPS    = tgfa_pkg::DEF_MAX_GROUPS,
   localparam int NODE_W       = $clog2(MAX_NODES),
   localparam int ADDR_W       = $clog2(MAX_NODES * tgfa_pkg::FANOUT),
   localparam int ENT_W        = tgfa_pkg::VAL_W + tgfa_pkg::EPOCH_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tgfa_pkg::cfg_type            cfg,
   input  logic                         start,
   input  logic [tgfa_pkg::KEY_W-1:0]   req_key,
   output logic                         busy,
   output logic                         rsp_valid,
   output logic [tgfa_pkg::STAT_W-1:0]  rsp_status,
   output logic [tgfa_pkg::GRP_W-1:0]   rsp_group_index,
   output logic                         ram_wr_en,
   output logic [ADDR_W-1:0]            ram_wr_addr,
   output logic [ENT_W-1:0]             ram_wr_data,
   output logic [ADDR_W-1:0]            ram_rd_addr,
   input  logic [ENT_W-1:0]             ram_rd_data
);
   import tgfa_pkg::*;

   localparam int DEPTH = MAX_NODES * FANOUT;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [EPOCH_W-1:0]  epoch_ff, epoch_in;
   logic [CNT_W-1:0]    nodes_used_ff, nodes_used_in;
   logic [CNT_W-1:0]    groups_used_ff, groups_used_in;
   logic [GC_W-1:0]     group_cost_ff, group_cost_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [LVL_W-1:0]    last_ff, last_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [LVL_W-1:0]    missing_ff, missing_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [GRP_W-1:0]    rsp_group_ff, rsp_group_in;

   logic [VAL_W-1:0]    entry_val;
   logic [EPOCH_W-1:0]  entry_tag;
   logic                hit;
   logic [VAL_W-1:0]    child;
   logic [NODE_W-1:0]   child_node;
   logic                at_last;
   logic [LVL_W-1:0]    depth_last;
   logic [CNT_W-1:0]    nodes_sum;
   logic [NEED_W-1:0]   need;
   logic                refuse;
   logic                wrap;

   assign entry_val  = ram_rd_data[VAL_W-1:0];
   assign entry_tag  = ram_rd_data[ENT_W-1:VAL_W];
   assign hit        = (entry_val != '0) && (entry_tag == epoch_ff);
   assign child      = entry_val - VAL_W'(1);
   assign child_node = child[NODE_W-1:0];
   assign at_last    = (lvl_ff == last_ff);
   assign wrap       = cfg.flush && (epoch_ff == '1);

   always_comb begin
      priority if (cfg.key_bytes == '0) begin
         depth_last = '0;
      end else if (cfg.key_bytes > KB_W'(MAX_KEY_BYTES)) begin
         depth_last = LVL_W'(MAX_KEY_BYTES - 1);
      end else begin
         depth_last = LVL_W'(cfg.key_bytes - KB_W'(1));
      end
   end

   // budget: nodes at 2 KiB each plus the tuple charge
   assign nodes_sum = nodes_used_ff + CNT_W'(missing_ff);
   assign need      = NEED_W'({nodes_sum, {NODE_SHIFT{1'b0}}}) + NEED_W'(group_cost_ff);
   assign refuse    = (nodes_sum > CNT_W'(MAX_NODES))
                   || (groups_used_ff >= CNT_W'(MAX_GROUPS))
                   || (need > NEED_W'(cfg.mem_bytes));

   assign group_cost_in = GC_W'(groups_used_ff + CNT_W'(1)) * GC_W'(cfg.tuple_bytes);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_addr_ff == ADDR_W'(DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (start) state_in = ST_WALK;
         ST_WALK: begin
            if (!hit) begin
               state_in = ST_CHECK;
            end else if (at_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_CHECK: state_in = refuse ? ST_IDLE : ST_ALLOC;
         ST_ALLOC: if (at_last) state_in = ST_IDLE;
      endcase
      if (wrap) begin
         state_in = ST_CLEAR;
      end
   end

   always_comb begin
      ram_wr_en      = 1'b0;
      ram_wr_addr    = clr_addr_ff;
      ram_wr_data    = '0;
      ram_rd_addr    = {node_ff, key_byte(key_ff, lvl_ff)};
      clr_addr_in    = clr_addr_ff;
      epoch_in       = epoch_ff;
      nodes_used_in  = nodes_used_ff;
      groups_used_in = groups_used_ff;
      key_in         = key_ff;
      last_in        = last_ff;
      lvl_in         = lvl_ff;
      node_in        = node_ff;
      missing_in     = missing_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_group_in   = rsp_group_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            ram_rd_addr = {NODE_W'(0), req_key[BYTE_W-1:0]};
            if (start) begin
               key_in  = req_key;
               last_in = depth_last;
               lvl_in  = '0;
               node_in = '0;
            end
         end
         ST_WALK: begin
            if (!hit) begin
               missing_in = last_ff - lvl_ff;
            end else if (at_last) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_FOUND;
               rsp_group_in  = child[GRP_W-1:0];
            end else begin
               node_in     = child_node;
               lvl_in      = lvl_ff + LVL_W'(1);
               ram_rd_addr = {child_node, key_byte(key_ff, lvl_ff + LVL_W'(1))};
            end
         end
         ST_CHECK: begin
            if (refuse) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_FULL;
               rsp_group_in  = '0;
            end
         end
         ST_ALLOC: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = {node_ff, key_byte(key_ff, lvl_ff)};
            if (at_last) begin
               ram_wr_data    = {epoch_ff, VAL_W'(groups_used_ff + CNT_W'(1))};
               groups_used_in = groups_used_ff + CNT_W'(1);
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STATUS_ADDED;
               rsp_group_in   = groups_used_ff[GRP_W-1:0];
            end else begin
               ram_wr_data   = {epoch_ff, VAL_W'(nodes_used_ff + CNT_W'(1))};
               node_in       = nodes_used_ff[NODE_W-1:0];
               nodes_used_in = nodes_used_ff + CNT_W'(1);
               lvl_in        = lvl_ff + LVL_W'(1);
            end
         end
      endcase
      // new key length: stale entries die with the old epoch
      if (cfg.flush) begin
         nodes_used_in  = CNT_W'(1);
         groups_used_in = '0;
         epoch_in       = epoch_ff + EPOCH_W'(1);
         if (wrap) begin
            clr_addr_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         epoch_ff       <= '0;
         nodes_used_ff  <= CNT_W'(1);
         groups_used_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         epoch_ff       <= epoch_in;
         nodes_used_ff  <= nodes_used_in;
         groups_used_ff <= groups_used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      group_cost_ff <= group_cost_in;
      key_ff        <= key_in;
      last_ff       <= last_in;
      lvl_ff        <= lvl_in;
      node_ff       <= node_in;
      missing_ff    <= missing_in;
      rsp_status_ff <= rsp_status_in;
      rsp_group_ff  <= rsp_group_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_group_index = rsp_group_ff;

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) != ST_IDLE)
      else $error("response without a request in flight");

   a_nodes_cap: assert property (@(posedge clock) disable iff (reset)
      nodes_used_ff <= CNT_W'(MAX_NODES))
      else $error("node count beyond capacity");

   a_groups_cap: assert property (@(posedge clock) disable iff (reset)
      groups_used_ff <= CNT_W'(MAX_GROUPS))
      else $error("group count beyond capacity");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      cfg.flush |=> (nodes_used_ff == CNT_W'(1)) && (groups_used_ff == '0))
      else $error("key length write did not empty the table");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_FULL) |-> rsp_group_ff == '0)
      else $error("refused insert with nonzero group index");

endmodule

>>> rtl/core/trie_group_find_or_add_core.sv
// Byte-wise 256-way trie, find or insert of a fixed-length group key.
// Request: pulse start with req_key while busy is low; the request is taken
// at that edge and busy rises the next cycle. Exactly one response follows:
// rsp_valid is high for one cycle with rsp_status (0 full, 1 found, 2 added)
// and rsp_group_index. The receiver cannot stall; the response register is
// written as busy falls, so a new request may be issued in the response cycle.
// With key_bytes the effective depth, a lookup does one node-table read per key
// byte, back to back through the RAM's registered read port. A miss goes
// through a budget check either to a full response or to an add that does
// one write per new node and one for the group. One request at a time.
// Registers (APB, pready tied high): 0x0 key_bytes, 0x4 tuple_bytes,
// 0x8 mem_bytes. Writing key_bytes empties the trie at once by bumping an
// 8-bit epoch held in every entry.
// Reset, and every 256th key_bytes write, starts a clearing pass over all
// MAX_NODES * 256 entries (65536 by default) during which busy stays high.
module trie_group_find_or_add_core #(
   parameter int MAX_KEY_BYTES = tgfa_pkg::DEF_MAX_KEY_BYTES,
   parameter int MAX_NODES     = tgfa_pkg::DEF_MAX_NODES,
   parameter int MAX_GROUPS    = tgfa_pkg::DEF_MAX_GROUPS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [tgfa_pkg::KEY_W-1:0]   req_key,
   output logic                         rsp_valid,
   output logic [tgfa_pkg::STAT_W-1:0]  rsp_status,
   output logic [tgfa_pkg::GRP_W-1:0]   rsp_group_index,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tgfa_pkg::PADDR_W-1:0] paddr,
   input  logic [tgfa_pkg::PDATA_W-1:0] pwdata,
   output logic [tgfa_pkg::PDATA_W-1:0] prdata,
   output logic                         pready
);
   import tgfa_pkg::*;

   localparam int DEPTH  = MAX_NODES * FANOUT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ENT_W  = VAL_W + EPOCH_W;

   cfg_type           cfg;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [ENT_W-1:0]  ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [ENT_W-1:0]  ram_rd_data;

   tgfa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tgfa_walk #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES),
      .MAX_NODES     (MAX_NODES),
      .MAX_GROUPS    (MAX_GROUPS)
   ) u_walk (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .start           (start),
      .req_key         (req_key),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_group_index (rsp_group_index),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data)
   );

   tgfa_ram #(
      .WIDTH (ENT_W),
      .DEPTH (DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

>>> test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tgfa_pkg::*;

   localparam int MAX_DEPTH    = DEF_MAX_KEY_BYTES;
   localparam int NODE_LIMIT   = DEF_MAX_NODES;
   localparam int GROUP_LIMIT  = DEF_MAX_GROUPS;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 2 * MAX_DEPTH + 4;
   localparam logic [63:0] NODE_COST = 64'd1 << NODE_SHIFT;
   localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

   typedef struct {
      logic [KEY_W-1:0]  key;
      logic [STAT_W-1:0] status;
      logic [GRP_W-1:0]  group_index;
   } lookup_type;

   logic                clock;
   logic                reset   = 1'b1;
   logic                start   = 1'b0;
   logic                busy;
   logic [KEY_W-1:0]    req_key = '0;
   logic                rsp_valid;
   logic [STAT_W-1:0]   rsp_status;
   logic [GRP_W-1:0]    rsp_group_index;
   logic                psel    = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite  = 1'b0;
   logic [PADDR_W-1:0]  paddr   = '0;
   logic [PDATA_W-1:0]  pwdata  = '0;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   trie_group_find_or_add_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_group_index (rsp_group_index),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // trie mirror: 0 = empty, else child index + 1
   logic [VAL_W-1:0] slot_tab [NODE_LIMIT*FANOUT];
   int unsigned      nodes_cnt;
   int unsigned      groups_cnt;
   logic [KB_W-1:0]  cfg_key_bytes;
   logic [TB_W-1:0]  cfg_tuple_bytes;
   logic [MB_W-1:0]  cfg_mem_bytes;

   lookup_type       pending_lookups [$];
   logic [KEY_W-1:0] known_keys [$];
   lookup_type       head;
   bit               start_on = 1'b0;
   bit               bus_held = 1'b0;
   int               fail_count = 0;
   int               requests_sent = 0;
   int               csr_writes = 0;
   int               found_seen = 0;
   int               added_seen = 0;
   int               full_seen = 0;
   int unsigned      cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned depth_of(logic [KB_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_DEPTH) return MAX_DEPTH;
      return int'(raw);
   endfunction

   function automatic void clear_slots(int unsigned node);
      for (int i = 0; i < FANOUT; i++) slot_tab[node*FANOUT + i] = '0;
   endfunction

   function automatic void empty_trie();
      clear_slots(0);
      nodes_cnt  = 1;
      groups_cnt = 0;
   endfunction

   function automatic lookup_type find_or_add(logic [KEY_W-1:0] key);
      lookup_type       r;
      int unsigned      depth;
      int unsigned      node;
      int unsigned      d;
      int unsigned      missing;
      int unsigned      fresh;
      bit               walking;
      logic [VAL_W-1:0] entry;
      logic [63:0]      need;
      r.key         = key;
      r.status      = STATUS_FULL;
      r.group_index = '0;
      depth   = depth_of(cfg_key_bytes);
      node    = 0;
      d       = 0;
      walking = 1'b1;
      while (walking && d < depth) begin
         entry = slot_tab[node*FANOUT + key[8*d +: 8]];
         if (entry == 0) begin
            walking = 1'b0;
         end else if (d == depth - 1) begin
            r.status      = STATUS_FOUND;
            r.group_index = GRP_W'(entry - 1);
            return r;
         end else begin
            node = entry - 1;
            d++;
         end
      end
      missing = depth - 1 - d;
      need = 64'(nodes_cnt + missing) * NODE_COST + 64'(groups_cnt + 1) * 64'(cfg_tuple_bytes);
      if (nodes_cnt + missing > NODE_LIMIT || groups_cnt >= GROUP_LIMIT ||
          need > 64'(cfg_mem_bytes))
         return r;
      while (d + 1 < depth) begin
         fresh = nodes_cnt;
         nodes_cnt++;
         clear_slots(fresh);
         slot_tab[node*FANOUT + key[8*d +: 8]] = VAL_W'(fresh + 1);
         node = fresh;
         d++;
      end
      slot_tab[node*FANOUT + key[8*d +: 8]] = VAL_W'(groups_cnt + 1);
      r.status      = STATUS_ADDED;
      r.group_index = GRP_W'(groups_cnt);
      groups_cnt++;
      return r;
   endfunction

   // mostly reuse or extend stored paths so lookups get past the first levels
   function automatic logic [KEY_W-1:0] next_key();
      logic [KEY_W-1:0] k;
      logic [KEY_W-1:0] base;
      int unsigned      depth;
      int unsigned      keep;
      int unsigned      pick;
      k     = {$urandom, $urandom};
      depth = depth_of(cfg_key_bytes);
      if (known_keys.size() == 0) return k;
      base = known_keys[$urandom_range(0, known_keys.size() - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 35) keep = depth;
      else if (pick < 70) keep = $urandom_range(0, depth - 1);
      else keep = 0;
      for (int b = 0; b < MAX_DEPTH; b++) begin
         if (b < keep) k[8*b +: 8] = base[8*b +: 8];
         else if (b < depth && $urandom_range(0, 1) == 1) k[8*b +: 8] = 8'($urandom_range(0, 3));
      end
      return k;
   endfunction

   task automatic drive_start(bit level);
      if (start_on != level) begin
         start    <= level;
         start_on  = level;
      end
   endtask

   task automatic settle();
      drive_start(1'b0);
      while (pending_lookups.size() != 0) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic issue_key(logic [KEY_W-1:0] key);
      if (bus_held) begin
         psel    <= 1'b0;
         bus_held = 1'b0;
      end
      drive_start(1'b1);
      req_key <= key;
      do @(posedge clock); while (busy !== 1'b0);
      pending_lookups.push_back(find_or_add(key));
      requests_sent++;
   endtask

   task automatic maybe_idle(int pct);
      if ($urandom_range(0, 99) < pct) begin
         drive_start(1'b0);
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic csr_write(logic [IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
      settle();
      if (!bus_held) begin
         psel    <= 1'b1;
         bus_held = 1'b1;
      end
      pwrite <= 1'b1;
      paddr  <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      penable <= 1'b0;
      csr_writes++;
      case (idx)
         REG_KEY_BYTES: begin
            cfg_key_bytes = value[KB_W-1:0];
            empty_trie();
         end
         REG_TUPLE_BYTES: cfg_tuple_bytes = value[TB_W-1:0];
         REG_MEM_BYTES:   cfg_mem_bytes = value[MB_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_read(logic [IDX_W-1:0] idx, logic [PDATA_W-1:0] want);
      settle();
      if (!bus_held) begin
         psel    <= 1'b1;
         bus_held = 1'b1;
      end
      pwrite <= 1'b0;
      paddr  <= {idx, 2'b00};
      pwdata <= '0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      penable <= 1'b0;
      if (prdata !== want) begin
         fail_count++;
         $display("%0t: register %0d readback: expected %h, got %h", $time, idx, want, prdata);
      end
   endtask

   task automatic test_reset_state();
      csr_read(REG_KEY_BYTES, PDATA_W'(KEY_BYTES_RST));
      csr_read(REG_TUPLE_BYTES, PDATA_W'(TUPLE_BYTES_RST));
      csr_read(REG_MEM_BYTES, PDATA_W'(MEM_BYTES_RST));
   endtask

   task automatic test_directed();
      // full depth, reset settings
      issue_key(64'h0);
      issue_key(64'hFFFF_FFFF_FFFF_FFFF);
      issue_key(64'h0);
      issue_key(64'h8000_0000_0000_0000);
      issue_key(64'h0000_0000_0000_0080);
      // writes to an unmapped address change nothing
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      issue_key(64'hFFFF_FFFF_FFFF_FFFF);
      // zero length acts as one byte
      csr_write(REG_KEY_BYTES, 32'h0);
      csr_read(REG_KEY_BYTES, 32'h0);
      issue_key(64'hABCD_0000_0000_00FF);
      issue_key(64'h0000_0000_0000_12FF);
      // oversize length acts as eight and empties the trie
      csr_write(REG_KEY_BYTES, 32'hF);
      issue_key(64'hFFFF_FFFF_FFFF_FFFF);
      // memory budget right at the boundary
      csr_write(REG_KEY_BYTES, 32'd2);
      csr_write(REG_TUPLE_BYTES, 32'd100);
      csr_write(REG_MEM_BYTES, 32'd4196);
      issue_key(64'h0101);
      issue_key(64'h0201);
      csr_write(REG_MEM_BYTES, 32'd4296);
      issue_key(64'h0201);
      issue_key(64'h0102);
      csr_write(REG_MEM_BYTES, 32'd0);
      issue_key(64'h0101);
      issue_key(64'h0301);
      csr_write(REG_TUPLE_BYTES, 32'hFFFF_FFFF);
      csr_write(REG_MEM_BYTES, 32'hFFFF_FFFF);
      csr_read(REG_TUPLE_BYTES, 32'h0000_FFFF);
      csr_read(REG_MEM_BYTES, 32'hFFFF_FFFF);
      issue_key(64'h0301);
   endtask

   task automatic run_phase(logic [PDATA_W-1:0] kb, logic [PDATA_W-1:0] tuple_val,
                            logic [PDATA_W-1:0] mem_val, int count, int idle_pct);
      logic [KEY_W-1:0] k;
      csr_write(REG_KEY_BYTES, kb);
      csr_write(REG_TUPLE_BYTES, tuple_val);
      csr_write(REG_MEM_BYTES, mem_val);
      for (int i = 0; i < count; i++) begin
         k = next_key();
         issue_key(k);
         known_keys.push_back(k);
         if (known_keys.size() > 512) void'(known_keys.pop_front());
         if ($urandom_range(0, 99) < 2) settle();
         else maybe_idle(idle_pct);
      end
   endtask

   task automatic test_random();
      run_phase(32'd8, 32'd8, 32'd1048576, 250, 30);
      run_phase(32'd1, 32'd65535, 32'hFFFF_FFFF, 150, 30);
      run_phase(32'd3, 32'd1, $urandom_range(20 * 2048, 60 * 2048), 250, 30);
      run_phase(32'd0, $urandom, $urandom_range(1 << 20, 32'hFFFF_FFFF), 150, 30);
      run_phase(32'd13, 32'd0, 32'hFFFF_FFFF, 200, 30);
      run_phase(32'd5, $urandom, $urandom_range(16384, 700000), 200, 30);
      run_phase(32'd2, 32'd4, 32'd1048576, 200, 0);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (rsp_status == STATUS_FOUND) found_seen++;
         else if (rsp_status == STATUS_ADDED) added_seen++;
         else full_seen++;
         if (pending_lookups.size() == 0) begin
            fail_count++;
            $display("%0t: response with no request outstanding: expected none, got %0d/%0d",
                     $time, rsp_status, rsp_group_index);
         end else begin
            head = pending_lookups.pop_front();
            if (rsp_status !== head.status) begin
               fail_count++;
               $display("%0t: key %h status: expected %0d, got %0d",
                        $time, head.key, head.status, rsp_status);
            end
            if (rsp_group_index !== head.group_index) begin
               fail_count++;
               $display("%0t: key %h group_index: expected %0d, got %0d",
                        $time, head.key, head.group_index, rsp_group_index);
            end
         end
      end
   end

   initial begin
      cfg_key_bytes   = KEY_BYTES_RST;
      cfg_tuple_bytes = TUPLE_BYTES_RST;
      cfg_mem_bytes   = MEM_BYTES_RST;
      empty_trie();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed();
      test_random();
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_lookups.size() != 0) begin
         fail_count++;
         $display("%0t: %0d responses never arrived", $time, pending_lookups.size());
      end
      $display("%0d requests checked (%0d found, %0d added, %0d refused), %0d register writes",
               requests_sent, found_seen, added_seen, full_seen, csr_writes);
      $display("depths 1 to 8 and out of range, memory budget, node limit, register readback");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/tgfa_pkg.sv
rtl/core/tgfa_ram.sv
rtl/core/tgfa_csr.sv
rtl/core/tgfa_walk.sv
rtl/core/trie_group_find_or_add_core.sv
test/tb.sv
